// ===== design/itch_pkg.sv =====
// ----------------------------------------------------------------------------
// ITCH field parser package
// Phase codes, layout tables and code decoding shared by the parser modules.
// ----------------------------------------------------------------------------
package itch_pkg;

	localparam logic [2:0] PH_LEN_HI = 3'd0;
	localparam logic [2:0] PH_LEN_LO = 3'd1;
	localparam logic [2:0] PH_TYPE   = 3'd2;
	localparam logic [2:0] PH_FIELD  = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_KIND      = 2'd1;
	localparam logic [1:0] ERR_CODE      = 2'd2;
	localparam logic [1:0] ERR_TRUNCATED = 2'd3;

	// Layout lookup for one kind and field.
	typedef struct packed {
		logic       known;
		logic [3:0] size;
		logic [3:0] table_sel;
		logic       last;
		logic       beyond;
	} layout_t;

	// One result item.
	typedef struct packed {
		logic [7:0]  kind;
		logic [4:0]  fnum;
		logic [63:0] value;
		logic [3:0]  size;
		logic [3:0]  code;
		logic        done;
		logic [1:0]  err;
	} result_t;

	// Maps a type byte to its dense kind index; 4'hF when unknown.
	function automatic logic [3:0] kind_index(input logic [7:0] k);
		case (k)
			"S": kind_index = 4'd0;
			"R": kind_index = 4'd1;
			"A": kind_index = 4'd2;
			"F": kind_index = 4'd3;
			"U": kind_index = 4'd4;
			"I": kind_index = 4'd5;
			"W": kind_index = 4'd6;
			"P": kind_index = 4'd7;
			"B": kind_index = 4'd8;
			default: kind_index = 4'hF;
		endcase
	endfunction

	function automatic logic [4:0] field_count(input logic [3:0] ki);
		case (ki)
			4'd0: field_count = 5'd4;
			4'd1: field_count = 5'd17;
			4'd2: field_count = 5'd8;
			4'd3: field_count = 5'd9;
			4'd4: field_count = 5'd7;
			4'd5: field_count = 5'd12;
			4'd6: field_count = 5'd4;
			4'd7: field_count = 5'd9;
			4'd8: field_count = 5'd4;
			default: field_count = 5'd0;
		endcase
	endfunction

	// Field size in bytes; the header fields are common to all kinds.
	function automatic logic [3:0] field_bytes(input logic [3:0] ki, input logic [4:0] f);
		field_bytes = 4'd1;
		if (f == 5'd0 || f == 5'd1) begin
			field_bytes = 4'd2;
		end else if (f == 5'd2) begin
			field_bytes = 4'd6;
		end else begin
			case (ki)
				4'd1: begin
					case (f)
						5'd3: field_bytes = 4'd8;
						5'd6, 5'd15: field_bytes = 4'd4;
						5'd9: field_bytes = 4'd2;
						default: field_bytes = 4'd1;
					endcase
				end
				4'd2, 4'd3, 4'd7: begin
					case (f)
						5'd3, 5'd6: field_bytes = 4'd8;
						5'd4: field_bytes = 4'd1;
						5'd8: field_bytes = (ki == 4'd7) ? 4'd8 : 4'd4;
						default: field_bytes = 4'd4;
					endcase
				end
				4'd4: field_bytes = (f == 5'd3 || f == 5'd4) ? 4'd8 : 4'd4;
				4'd5: begin
					case (f)
						5'd3, 5'd4, 5'd6: field_bytes = 4'd8;
						5'd7, 5'd8, 5'd9: field_bytes = 4'd4;
						default: field_bytes = 4'd1;
					endcase
				end
				4'd8: field_bytes = 4'd8;
				default: field_bytes = 4'd1;
			endcase
		end
	endfunction

	// Code set that checks a field; 0 when the field passes raw.
	function automatic logic [3:0] field_table(input logic [3:0] ki, input logic [4:0] f);
		field_table = 4'd0;
		case (ki)
			4'd0: if (f == 5'd3) field_table = 4'd1;
			4'd1: begin
				case (f)
					5'd4: field_table = 4'd2;
					5'd5: field_table = 4'd3;
					5'd13: field_table = 4'd4;
					default: field_table = 4'd0;
				endcase
			end
			4'd2, 4'd3, 4'd7: if (f == 5'd4) field_table = 4'd5;
			4'd5: begin
				if (f == 5'd5) field_table = 4'd6;
				else if (f == 5'd10) field_table = 4'd7;
			end
			4'd6: if (f == 5'd3) field_table = 4'd8;
			default: field_table = 4'd0;
		endcase
	endfunction

	// Dense code index; bit 4 set when the byte is not in the set.
	function automatic logic [4:0] code_index(input logic [3:0] t, input logic [7:0] c);
		code_index = 5'h10;
		case (t)
			4'd1: begin
				case (c)
					"O": code_index = 5'd0; "S": code_index = 5'd1;
					"Q": code_index = 5'd2; "M": code_index = 5'd3;
					"E": code_index = 5'd4; "C": code_index = 5'd5;
					default: code_index = 5'h10;
				endcase
			end
			4'd2: begin
				case (c)
					"Q": code_index = 5'd0; "G": code_index = 5'd1;
					"S": code_index = 5'd2; "N": code_index = 5'd3;
					"A": code_index = 5'd4; "P": code_index = 5'd5;
					"Z": code_index = 5'd6; "V": code_index = 5'd7;
					" ": code_index = 5'd8;
					default: code_index = 5'h10;
				endcase
			end
			4'd3: begin
				case (c)
					"N": code_index = 5'd0; "D": code_index = 5'd1;
					"E": code_index = 5'd2; "Q": code_index = 5'd3;
					"S": code_index = 5'd4; "G": code_index = 5'd5;
					"H": code_index = 5'd6; "J": code_index = 5'd7;
					"K": code_index = 5'd8; "C": code_index = 5'd9;
					" ": code_index = 5'd10;
					default: code_index = 5'h10;
				endcase
			end
			4'd4: begin
				case (c)
					"1": code_index = 5'd0; "2": code_index = 5'd1;
					" ": code_index = 5'd2;
					default: code_index = 5'h10;
				endcase
			end
			4'd5: begin
				case (c)
					"B": code_index = 5'd0; "S": code_index = 5'd1;
					default: code_index = 5'h10;
				endcase
			end
			4'd6: begin
				case (c)
					"B": code_index = 5'd0; "S": code_index = 5'd1;
					"N": code_index = 5'd2; "O": code_index = 5'd3;
					default: code_index = 5'h10;
				endcase
			end
			4'd7: begin
				case (c)
					"O": code_index = 5'd0; "C": code_index = 5'd1;
					"H": code_index = 5'd2; "A": code_index = 5'd3;
					default: code_index = 5'h10;
				endcase
			end
			4'd8: begin
				case (c)
					"1": code_index = 5'd0; "2": code_index = 5'd1;
					"3": code_index = 5'd2;
					default: code_index = 5'h10;
				endcase
			end
			default: code_index = 5'h10;
		endcase
	endfunction

endpackage

// ===== design/itch_message_field_parser.sv =====
// ----------------------------------------------------------------------------
// ITCH message field parser
// Parses length-prefixed market data messages into big-endian fields.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the input is not stalled, with no gaps of
// its own; each byte runs through the parse state and layout tables
// combinationally and any field result lands in a one-deep output register,
// so a result appears in the cycle after its last byte. The input stalls
// whenever a result is waiting in the output register and the sink is
// stalling it, whether or not the next byte would produce a result.
module itch_message_field_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  message_kind,
	output logic [4:0]  field_number,
	output logic [63:0] field_value,
	output logic [3:0]  field_size,
	output logic [3:0]  decoded_code,
	output logic        message_done,
	output logic [1:0]  error_kind
);
	import itch_pkg::*;

	logic [2:0]  phase_q;
	logic [15:0] len_q;
	logic [15:0] cnt_q;
	logic [7:0]  kind_q;
	logic [4:0]  fld_q;
	logic [3:0]  fby_q;
	logic [63:0] acc_q;
	result_t     res_q;
	logic        rv_q;

	logic [2:0]  phase_d;
	logic [15:0] len_d;
	logic [15:0] cnt_d;
	logic [7:0]  kind_d;
	logic [4:0]  fld_d;
	logic [3:0]  fby_d;
	logic [63:0] acc_d;
	result_t     res_d;
	logic        emit;
	logic        take;
	layout_t     lay;
	logic [4:0]  cidx;

	assign in_stall = rv_q && out_stall;
	assign take = in_valid && !in_stall;

	itch_layout u_layout (
		.kind(kind_q),
		.fnum(fld_q),
		.lay (lay)
	);

	assign cidx = code_index(lay.table_sel, data_byte);

	// Next parse state and result for one byte.
	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		cnt_d = cnt_q;
		kind_d = kind_q;
		fld_d = fld_q;
		fby_d = fby_q;
		acc_d = acc_q;
		res_d = '0;
		emit = 1'b0;
		case (phase_q)
			PH_LEN_LO: begin
				len_d = {len_q[15:8], data_byte};
				phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				kind_d = data_byte;
				cnt_d = 16'd1;
				fld_d = '0;
				fby_d = '0;
				acc_d = '0;
				if (kind_index(data_byte) == 4'hF) begin
					res_d = '{kind: data_byte, fnum: 5'd0, value: 64'd0, size: 4'd0,
						code: 4'd0, done: 1'b1, err: ERR_KIND};
					emit = 1'b1;
					phase_d = (16'd1 < len_q) ? PH_SKIP : PH_LEN_HI;
				end else begin
					phase_d = PH_FIELD;
				end
			end
			PH_FIELD: begin
				if (!lay.known || lay.beyond) begin
					phase_d = PH_LEN_HI;
					kind_d = '0;
					fld_d = '0;
					fby_d = '0;
					acc_d = '0;
				end else begin
					acc_d = {acc_q[55:0], data_byte};
					fby_d = fby_q + 4'd1;
					if (cnt_q != 16'hFFFF) cnt_d = cnt_q + 16'd1;
					if (fby_d >= lay.size) begin
						emit = 1'b1;
						if (lay.table_sel != 4'd0 && cidx[4]) begin
							res_d = '{kind: kind_q, fnum: fld_q, value: acc_d, size: lay.size,
								code: 4'd0, done: 1'b1, err: ERR_CODE};
							phase_d = (cnt_d < len_q) ? PH_SKIP : PH_LEN_HI;
						end else begin
							res_d = '{kind: kind_q, fnum: fld_q, value: acc_d, size: lay.size,
								code: (lay.table_sel != 4'd0) ? cidx[3:0] : 4'd0,
								done: lay.last, err: ERR_NONE};
							if (lay.last) begin
								phase_d = (cnt_d < len_q) ? PH_SKIP : PH_LEN_HI;
							end else begin
								fld_d = fld_q + 5'd1;
								fby_d = '0;
								acc_d = '0;
							end
						end
					end
				end
			end
			PH_SKIP: begin
				if (cnt_q != 16'hFFFF) cnt_d = cnt_q + 16'd1;
				if (cnt_d >= len_q) phase_d = PH_LEN_HI;
			end
			default: begin
				kind_d = '0;
				fld_d = '0;
				fby_d = '0;
				acc_d = '0;
				len_d = {data_byte, 8'd0};
				cnt_d = '0;
				phase_d = PH_LEN_LO;
			end
		endcase
		// End of stream: report truncation of a message in progress and return to reset state.
		if (stream_end) begin
			if (phase_d == PH_LEN_LO || phase_d == PH_TYPE || phase_d == PH_FIELD) begin
				res_d = '{kind: kind_d, fnum: fld_d, value: acc_d, size: fby_d,
					code: 4'd0, done: 1'b1, err: ERR_TRUNCATED};
				emit = 1'b1;
			end
			phase_d = PH_LEN_HI;
			len_d = '0;
			cnt_d = '0;
			kind_d = '0;
			fld_d = '0;
			fby_d = '0;
			acc_d = '0;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN_HI;
			len_q <= '0;
			cnt_q <= '0;
			kind_q <= '0;
			fld_q <= '0;
			fby_q <= '0;
			acc_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			len_q <= len_d;
			cnt_q <= cnt_d;
			kind_q <= kind_d;
			fld_q <= fld_d;
			fby_q <= fby_d;
			acc_q <= acc_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (take && emit) begin
			rv_q <= 1'b1;
		end else if (!out_stall) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = rv_q;
	assign message_kind = res_q.kind;
	assign field_number = res_q.fnum;
	assign field_value = res_q.value;
	assign field_size = res_q.size;
	assign decoded_code = res_q.code;
	assign message_done = res_q.done;
	assign error_kind = res_q.err;

endmodule

// ===== design/itch_layout.sv =====
// ----------------------------------------------------------------------------
// ITCH layout lookup
// Gives size, code set and position flags of the current field of a kind.
// ----------------------------------------------------------------------------
module itch_layout (
	input  logic [7:0]       kind,
	input  logic [4:0]       fnum,
	output itch_pkg::layout_t lay
);
	import itch_pkg::*;

	logic [3:0] ki;
	logic [4:0] cnt;

	// Table lookup for the field in progress.
	always_comb begin
		ki = kind_index(kind);
		cnt = field_count(ki);
		lay.known = (ki != 4'hF);
		lay.size = field_bytes(ki, fnum);
		lay.table_sel = field_table(ki, fnum);
		lay.last = ((fnum + 5'd1) >= cnt);
		lay.beyond = (fnum >= cnt);
	end

endmodule

// ===== verif/itch_field_checker.sv =====
// ----------------------------------------------------------------------------
// ITCH field parser checker
// Watches both channels, predicts every field result from the accepted bytes
// and compares the results the parser delivers, in order.
// ----------------------------------------------------------------------------
module itch_field_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  message_kind,
	input  logic [4:0]  field_number,
	input  logic [63:0] field_value,
	input  logic [3:0]  field_size,
	input  logic [3:0]  decoded_code,
	input  logic        message_done,
	input  logic [1:0]  error_kind,
	output int          fail_count,
	output int          pending_fields,
	output int          field_total,
	output int          error_total
);
	timeunit 1ns;
	timeprecision 1ps;
	import itch_pkg::*;

	typedef struct packed {
		logic [7:0]  kind;
		logic [4:0]  fnum;
		logic [63:0] value;
		logic [3:0]  size;
		logic [3:0]  code;
		logic        done;
		logic [1:0]  err;
	} field_rec_t;

	field_rec_t expected_fields[$];

	// Parser state mirror.
	logic [2:0]  phase;
	logic [15:0] msg_len;
	logic [15:0] msg_pos;
	logic [7:0]  kind_byte;
	logic [4:0]  fld;
	logic [3:0]  fld_pos;
	logic [63:0] acc;

	function automatic int kind_slot(input logic [7:0] k);
		case (k)
			"S": return 0; "R": return 1; "A": return 2; "F": return 3;
			"U": return 4; "I": return 5; "W": return 6; "P": return 7;
			"B": return 8;
			default: return -1;
		endcase
	endfunction

	function automatic int layout_len(input int ks);
		int counts[9] = '{4, 17, 8, 9, 7, 12, 4, 9, 4};
		return counts[ks];
	endfunction

	function automatic int layout_size(input int ks, input int f);
		int sz[9][17] = '{
			'{2, 2, 6, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{2, 2, 6, 8, 1, 1, 4, 1, 1, 2, 1, 1, 1, 1, 1, 4, 1},
			'{2, 2, 6, 8, 1, 4, 8, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{2, 2, 6, 8, 1, 4, 8, 4, 4, 0, 0, 0, 0, 0, 0, 0, 0},
			'{2, 2, 6, 8, 8, 4, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{2, 2, 6, 8, 8, 1, 8, 4, 4, 4, 1, 1, 0, 0, 0, 0, 0},
			'{2, 2, 6, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{2, 2, 6, 8, 1, 4, 8, 4, 8, 0, 0, 0, 0, 0, 0, 0, 0},
			'{2, 2, 6, 8, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}};
		return sz[ks][f];
	endfunction

	// Returns the code string checking a field, empty when raw.
	function automatic string code_set(input int ks, input int f);
		case (ks)
			0: if (f == 3) return "OSQMEC";
			1: if (f == 4) return "QGSNAPZV ";
				else if (f == 5) return "NDEQSGHJKC ";
				else if (f == 13) return "12 ";
			2, 3, 7: if (f == 4) return "BS";
			5: if (f == 5) return "BSNO";
				else if (f == 10) return "OCHA";
			6: if (f == 3) return "123";
			default: ;
		endcase
		return "";
	endfunction

	task automatic clear_all();
		phase = PH_LEN_HI; msg_len = '0; msg_pos = '0;
		kind_byte = '0; fld = '0; fld_pos = '0; acc = '0;
	endtask

	task automatic push_field(input logic [7:0] k, input logic [4:0] f, input logic [63:0] v,
			input logic [3:0] s, input logic [3:0] c, input logic d, input logic [1:0] e);
		field_rec_t r;
		r = '{k, f, v, s, c, d, e};
		expected_fields.push_back(r);
	endtask

	// Advances the mirror by one byte and queues what it produces.
	task automatic parse_byte(input logic [7:0] b, input logic last_byte);
		int ks;
		int cidx;
		string cs;
		logic have;
		field_rec_t r;
		have = 0;
		case (phase)
			PH_LEN_LO: begin
				msg_len[7:0] = b; phase = PH_TYPE;
			end
			PH_TYPE: begin
				kind_byte = b; msg_pos = 1; fld = 0; fld_pos = 0; acc = 0;
				if (kind_slot(b) < 0) begin
					r = '{b, 5'd0, 64'd0, 4'd0, 4'd0, 1'b1, ERR_KIND}; have = 1;
					phase = (msg_pos < msg_len) ? PH_SKIP : PH_LEN_HI;
				end else begin
					phase = PH_FIELD;
				end
			end
			PH_FIELD: begin
				ks = kind_slot(kind_byte);
				acc = {acc[55:0], b};
				fld_pos = fld_pos + 1;
				if (msg_pos != 16'hFFFF) msg_pos = msg_pos + 1;
				if (fld_pos >= layout_size(ks, fld)) begin
					cs = code_set(ks, fld);
					cidx = 0;
					if (cs.len() != 0) begin
						cidx = -1;
						for (int i = 0; i < cs.len(); i++)
							if (cs[i] == b && cidx < 0) cidx = i;
					end
					if (cidx < 0) begin
						r = '{kind_byte, fld, acc, 4'(layout_size(ks, fld)), 4'd0, 1'b1,
							ERR_CODE};
						phase = (msg_pos < msg_len) ? PH_SKIP : PH_LEN_HI;
					end else begin
						r = '{kind_byte, fld, acc, 4'(layout_size(ks, fld)), 4'(cidx),
							1'b0, ERR_NONE};
						if (fld + 1 >= layout_len(ks)) begin
							r.done = 1;
							phase = (msg_pos < msg_len) ? PH_SKIP : PH_LEN_HI;
						end else begin
							fld = fld + 1; fld_pos = 0; acc = 0;
						end
					end
					have = 1;
				end
			end
			PH_SKIP: begin
				if (msg_pos != 16'hFFFF) msg_pos = msg_pos + 1;
				if (msg_pos >= msg_len) phase = PH_LEN_HI;
			end
			default: begin
				kind_byte = 0; fld = 0; fld_pos = 0; acc = 0;
				msg_len = {b, 8'h00}; msg_pos = 0; phase = PH_LEN_LO;
			end
		endcase
		if (last_byte) begin
			if (phase == PH_LEN_LO || phase == PH_TYPE || phase == PH_FIELD) begin
				r = '{kind_byte, fld, acc, fld_pos, 4'd0, 1'b1, ERR_TRUNCATED};
				have = 1;
			end
			clear_all();
		end
		if (have) expected_fields.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	field_rec_t want;
	field_rec_t got;

	initial begin
		fail_count = 0; field_total = 0; error_total = 0; pending_fields = 0;
		clear_all();
	end

	// Compare each delivered result against the oldest prediction, then
	// predict from the byte taken on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{message_kind, field_number, field_value, field_size, decoded_code,
					message_done, error_kind};
				field_total++;
				if (error_kind != ERR_NONE) error_total++;
				if (expected_fields.size() == 0) begin
					report_mismatch("unexpected result, kind", 64'(got.kind), 64'd0);
				end else begin
					want = expected_fields.pop_front();
					if (got.kind !== want.kind)
						report_mismatch("kind", 64'(got.kind), 64'(want.kind));
					if (got.fnum !== want.fnum)
						report_mismatch("field", 64'(got.fnum), 64'(want.fnum));
					if (got.value !== want.value) report_mismatch("value", got.value, want.value);
					if (got.size !== want.size)
						report_mismatch("size", 64'(got.size), 64'(want.size));
					if (got.code !== want.code)
						report_mismatch("code", 64'(got.code), 64'(want.code));
					if (got.done !== want.done)
						report_mismatch("done", 64'(got.done), 64'(want.done));
					if (got.err !== want.err)
						report_mismatch("error", 64'(got.err), 64'(want.err));
				end
			end
			if (in_valid && !in_stall) parse_byte(data_byte, stream_end);
			pending_fields <= expected_fields.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// ITCH field parser testbench
// Feeds directed and random message streams, idles both sides at random and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  data_byte = 0;
	logic        stream_end = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [7:0]  message_kind;
	logic [4:0]  field_number;
	logic [63:0] field_value;
	logic [3:0]  field_size;
	logic [3:0]  decoded_code;
	logic        message_done;
	logic [1:0]  error_kind;
	int          fail_count;
	int          pending_fields;
	int          field_total;
	int          error_total;
	logic        calm = 0;
	int          requests_sent = 0;

	always #1 clk = ~clk;

	itch_message_field_parser dut (.*);

	itch_field_checker chk (.*);

	// Sink stalls at random, about 23 times in a hundred, never during the calm window.
	always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 23);

	// Sends one request, idling beforehand at random.
	task automatic send_byte(input logic [7:0] b, input logic e);
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; data_byte <= b; stream_end <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
	endtask

	// Body code choices for coded fields.
	function automatic logic [7:0] pick_code(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	// Sends one message; corrupt adds a bad code, extra adds surplus length.
	task automatic send_message(input logic [7:0] kind, input bit corrupt, input int extra,
			input bit short_len, input bit cut);
		int sizes[$];
		string codes[$];
		int body;
		int len;
		int bad_at;
		logic [7:0] b;
		case (kind)
			"S": begin sizes = '{2, 2, 6, 1}; codes = '{"", "", "", "OSQMEC"}; end
			"R": begin
				sizes = '{2, 2, 6, 8, 1, 1, 4, 1, 1, 2, 1, 1, 1, 1, 1, 4, 1};
				codes = '{"", "", "", "", "QGSNAPZV ", "NDEQSGHJKC ", "", "", "", "", "",
					"", "", "12 ", "", "", ""};
			end
			"A": begin sizes = '{2, 2, 6, 8, 1, 4, 8, 4}; codes = '{"", "", "", "", "BS", "", "", ""}; end
			"F": begin
				sizes = '{2, 2, 6, 8, 1, 4, 8, 4, 4};
				codes = '{"", "", "", "", "BS", "", "", "", ""};
			end
			"U": begin sizes = '{2, 2, 6, 8, 8, 4, 4}; codes = '{"", "", "", "", "", "", ""}; end
			"I": begin
				sizes = '{2, 2, 6, 8, 8, 1, 8, 4, 4, 4, 1, 1};
				codes = '{"", "", "", "", "", "BSNO", "", "", "", "", "OCHA", ""};
			end
			"W": begin sizes = '{2, 2, 6, 1}; codes = '{"", "", "", "123"}; end
			"P": begin
				sizes = '{2, 2, 6, 8, 1, 4, 8, 4, 8};
				codes = '{"", "", "", "", "BS", "", "", "", ""};
			end
			"B": begin sizes = '{2, 2, 6, 8}; codes = '{"", "", "", ""}; end
			default: begin sizes = '{}; codes = '{}; end
		endcase
		body = 1;
		foreach (sizes[i]) body += sizes[i];
		len = short_len ? $urandom_range(body - 1) : body + extra;
		bad_at = -1;
		if (corrupt) begin
			foreach (codes[i]) if (codes[i].len() != 0) bad_at = i;
		end
		send_byte(len[15:8], 0);
		send_byte(len[7:0], 0);
		send_byte(kind, cut && sizes.size() == 0);
		if (sizes.size() == 0) begin
			for (int i = 1; i < len && !cut; i++) send_byte(8'($urandom), 0);
		end else begin
			foreach (sizes[f]) begin
				for (int j = 0; j < sizes[f]; j++) begin
					b = 8'($urandom);
					if (codes[f].len() != 0) b = pick_code(codes[f]);
					if (f == bad_at) b = "x";
					if (cut && f == sizes.size() - 2 && j == sizes[f] - 1) begin
						send_byte(b, 1);
						return;
					end
					send_byte(b, 0);
					if (f == bad_at) break;
				end
				if (f == bad_at) break;
			end
			if (!short_len)
				for (int i = 0; i < extra; i++) send_byte(8'($urandom), 0);
		end
	endtask

	string kinds = "SRAFUIWPB";
	int rnd;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: every kind, extreme bytes, errors, surplus and short length.
		foreach (kinds[i]) send_message(kinds[i], 0, 0, 0, 0);
		send_message("Z", 0, 3, 0, 0);
		send_message("S", 1, 0, 0, 0);
		send_message("R", 1, 2, 0, 0);
		send_message("I", 1, 0, 0, 0);
		send_message("A", 0, 4, 0, 0);
		send_message("U", 0, 0, 1, 0);
		send_byte(8'hFF, 0); send_byte(8'h00, 1);
		send_byte(8'h00, 0); send_byte(8'h0B, 0); send_byte("S", 1);
		send_message("P", 0, 0, 0, 1);
		send_byte(8'h00, 1);
		send_message("B", 0, 0, 0, 0);
		send_byte(8'hFF, 0); send_byte(8'hFF, 0); send_byte("Q", 0); send_byte(8'h00, 1);

		// Hold off until every predicted result has been delivered.
		in_valid <= 0;
		@(posedge clk);
		while (pending_fields != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		// Random: mostly well-formed messages, some broken ones and noise.
		while (requests_sent < 1450 * 1) begin
			calm <= (requests_sent > 700 && requests_sent < 850);
			rnd = $urandom_range(99);
			if (rnd < 70)
				send_message(kinds[$urandom_range(8)], 0, ($urandom_range(3) == 0) ?
					$urandom_range(5) : 0, 0, 0);
			else if (rnd < 78) send_message(kinds[$urandom_range(8)], 1, 0, 0, 0);
			else if (rnd < 84)
				send_message(8'($urandom_range(255)), 0, $urandom_range(4), 0, 0);
			else if (rnd < 90) send_message(kinds[$urandom_range(8)], 0, 0, 1, 0);
			else if (rnd < 95) send_message(kinds[$urandom_range(8)], 0, 0, 0, 1);
			else send_byte(8'($urandom), 1'($urandom_range(1)));
		end
		calm <= 0;
		in_valid <= 0;
		@(posedge clk);
		while (pending_fields != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d requests; checked %0d field results, %0d of them errors.",
			requests_sent, field_total, error_total);
		if (fail_count == 0) begin
			$display("itch_message_field_parser: match");
		end else begin
			$display("itch_message_field_parser: mismatch");
		end
		$finish;
	end

	// Timeout guard.
	initial begin
		#400000;
		$display("itch_message_field_parser: mismatch");
		$finish;
	end

endmodule

// ===== itch_message_field_parser.f =====
design/itch_pkg.sv
design/itch_layout.sv
design/itch_message_field_parser.sv
verif/itch_field_checker.sv
verif/tb_top.sv
